@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL of the positional list block.
// Stands alone; the including file supplies clock and reset names as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent in one cycle implies a consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/plid_pkg.sv @@
// Types and codes for the positional list insert/delete block.
// No dependencies; imported by the top level.
package plid_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int POS_W        = 16;
   localparam int VALUE_W      = 32;
   localparam int LEN_W        = 7;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]                kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] read_value;
      logic [LEN_W-1:0]          list_length;
   } rsp_type;

endpackage

@@ hw/rtl/positional_list_insert_delete_core.sv @@
// Positional list: ordered store of signed 32-bit values with insert, delete and read.
// Depends on plid_pkg and assert_macros.svh.
//
// Usage: each req_ transfer carries one operation (insert, delete or read at a
// one-based position); each produces exactly one rsp_ transfer with a status,
// the value read (zero unless a read succeeds) and the list length afterwards.
// The entries live in a row of CAPACITY registers; every entry compares its own
// index with the position and shifts up, shifts down, loads or holds in the
// same cycle, so one operation completes per cycle while rsp_ready does not stall.
// Order: the input register takes the item at the req_ transfer and the result
// register takes the result from it once the result register is free, raising
// rsp_valid. Throughput: one operation per cycle unless rsp_ready stalls, as the
// entry row and the counter update together.
// Stalls: while rsp_ready is low a finished result holds in the result register
// and one more operation may wait in the input register; req_ready drops only
// when both are occupied.
// Reset: synchronous, active high; empties the list and clears both valid bits.
// Entry contents are not cleared and are never read before being written.
`include "assert_macros.svh"

module positional_list_insert_delete_core
   import plid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMPW = POS_W + 1;
   localparam int LXW  = (CW > LEN_W) ? CW : LEN_W;

   logic              req_vld_ff;
   req_type           req_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [VALUE_W-1:0] cell_ff [CAPACITY];

   logic              adv;
   logic [1:0]        status;
   logic              do_ins;
   logic              do_del;
   logic [POS_W-1:0]  pm1;
   logic [CMPW-1:0]   pos_x;
   logic [CMPW-1:0]   cnt_x;
   logic [VALUE_W-1:0] rd_val;
   logic [LXW-1:0]    len_x;

   assign adv       = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign pos_x = CMPW'(req_ff.position);
   assign cnt_x = CMPW'(count_ff);
   assign pm1   = req_ff.position - POS_W'(1);

   always_comb begin
      status = ST_INVALID;
      case (req_ff.kind)
         KIND_INSERT: begin
            if (req_ff.position == '0) begin
               status = ST_INVALID;
            end else if (pos_x > cnt_x + CMPW'(1)) begin
               status = ST_RANGE;
            end else if (cnt_x >= CMPW'(CAPACITY)) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
            end
         end
         KIND_DELETE, KIND_READ: begin
            if (count_ff == '0 || req_ff.position == '0) begin
               status = ST_INVALID;
            end else if (pos_x > cnt_x) begin
               status = ST_RANGE;
            end else begin
               status = ST_OK;
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

   assign do_ins = adv && (req_ff.kind == KIND_INSERT) && (status == ST_OK);
   assign do_del = adv && (req_ff.kind == KIND_DELETE) && (status == ST_OK);

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // The position is only trusted as an index once the status is OK.
   assign rd_val = (req_ff.kind == KIND_READ && status == ST_OK) ?
                   cell_ff[pm1[IW-1:0]] : '0;
   assign len_x  = LXW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (adv) begin
         rsp_ff.status      <= status;
         rsp_ff.read_value  <= rd_val;
         rsp_ff.list_length <= len_x[LEN_W-1:0];
      end
   end

   // Each entry looks only at its neighbors and its own index against the position.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [POS_W-1:0] IDX = POS_W'(i);
      always_ff @(posedge clock) begin
         if (do_ins && IDX == pm1) begin
            cell_ff[i] <= req_ff.item_value;
         end else if (do_ins && IDX > pm1) begin
            cell_ff[i] <= cell_ff[(i > 0) ? i - 1 : 0];
         end else if (do_del && IDX >= pm1 && i < CAPACITY - 1) begin
            cell_ff[i] <= cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY),
      "list length exceeds capacity")
   `ASSERT_NEXT(a_fail_holds_count, clock, reset, adv && status != ST_OK,
      count_ff == $past(count_ff), "failed operation changed the list length")
   `ASSERT_NEXT(a_insert_grows, clock, reset, do_ins,
      count_ff == $past(count_ff) + CW'(1), "successful insert did not grow the list")
   `ASSERT_CLK(a_read_zero, clock, reset,
      !rsp_vld_ff || rsp_ff.status == ST_OK || rsp_ff.read_value == '0,
      "failed operation returned a nonzero read value")

endmodule
